[src/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int ENTRIES     = 16;
  localparam int ID_COUNT    = 16;
  localparam int ID_W        = 4;
  localparam int DLY_W       = 16;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int TPS_W       = 8;
  localparam logic [TPS_W-1:0] TICKS_RESET = 8'd60;

  // input operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  // result kinds
  localparam logic [1:0] EV_EXPIRED   = 2'd0;
  localparam logic [1:0] EV_CANCELLED = 2'd1;
  localparam logic [1:0] EV_EMPTY     = 2'd2;
  localparam logic [1:0] EV_REJECTED  = 2'd3;

  // one list node, stored per id
  typedef struct packed {
    logic [ID_W-1:0]  nxt;
    logic [DLY_W-1:0] dly;
  } node_t;

  // result word from the sequencer to the output register
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [1:0]      kind;
    logic            last;
  } event_t;

endpackage

[src/dtq_ram.sv]
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/dtq_ctrl.sv]
// ----------------------------------------------------------------------------
// dtq_ctrl
// List sequencer: linked delta list held in node RAM indexed by id, with
// head pointer, count, queued flags and the tick prescaler in flops.
// ----------------------------------------------------------------------------
module dtq_ctrl import dtq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [ID_W-1:0]  in_entry_id,
  input  logic [DLY_W-1:0] in_delay,
  input  logic [TPS_W-1:0] tps,
  input  logic             slot_free,
  output event_t           ev
);

  typedef enum logic [3:0] {
    S_IDLE, S_ONE, S_TK_RD, S_TK_DEC, S_REL_RD, S_REL_CHK, S_REL_EMIT,
    S_IN_RD, S_IN_CMP, S_IN_NEW, S_IN_SUCC, S_IN_LINK,
    S_CN_RD, S_CN_A, S_CN_B, S_CN_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_COUNT-1:0] flags_r, flags_nxt;
  logic [TPS_W-1:0]    presc_r, presc_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [DLY_W-1:0]    rem_r, rem_nxt;
  logic [ID_W-1:0]     nxt_r, nxt_nxt;
  logic [ID_W-1:0]     nn_r, nn_nxt;
  logic [ID_W-1:0]     prev_r, prev_nxt;
  logic [DLY_W-1:0]    prev_dly_r, prev_dly_nxt;
  logic                prev_v_r, prev_v_nxt;
  logic [DLY_W-1:0]    succ_dly_r, succ_dly_nxt;
  logic                end_r, end_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                more_r, more_nxt;

  logic                wr_en;
  logic [ID_W-1:0]     wr_addr, rd_addr;
  node_t               wr_node, rd_node;
  logic [TPS_W-1:0]    presc_inc;
  logic [DLY_W:0]      sum;
  logic [CNT_W-1:0]    k_inc;

  dtq_ram #(.WIDTH($bits(node_t)), .DEPTH(ID_COUNT)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_node),
    .rd_addr (rd_addr),
    .rd_data (rd_node)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign presc_inc = presc_r + 1'b1;
  assign sum       = {1'b0, rd_node.dly} + {1'b0, rem_r};
  assign k_inc     = k_r + 1'b1;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    flags_nxt    = flags_r;
    presc_nxt    = presc_r;
    id_nxt       = id_r;
    kind_nxt     = kind_r;
    rem_nxt      = rem_r;
    nxt_nxt      = nxt_r;
    nn_nxt       = nn_r;
    prev_nxt     = prev_r;
    prev_dly_nxt = prev_dly_r;
    prev_v_nxt   = prev_v_r;
    succ_dly_nxt = succ_dly_r;
    end_nxt      = end_r;
    k_nxt        = k_r;
    more_nxt     = more_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_node      = '0;
    rd_addr      = head_r;
    ev           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt = in_entry_id;
          case (in_op)
            OP_TICK: begin
              if (presc_inc >= tps) begin
                presc_nxt = '0;
                if (count_r != '0) state_nxt = S_TK_RD;
              end else begin
                presc_nxt = presc_inc;
              end
            end
            OP_INSERT: begin
              if (flags_r[in_entry_id] || count_r >= CNT_W'(ENTRIES)) begin
                kind_nxt  = EV_REJECTED;
                state_nxt = S_ONE;
              end else begin
                rem_nxt    = in_delay;
                nxt_nxt    = head_r;
                prev_v_nxt = 1'b0;
                k_nxt      = '0;
                end_nxt    = (count_r == '0);
                state_nxt  = (count_r == '0) ? S_IN_NEW : S_IN_RD;
              end
            end
            OP_CANCEL: begin
              if (count_r == '0) begin
                id_nxt    = '0;
                kind_nxt  = EV_EMPTY;
                state_nxt = S_ONE;
              end else begin
                state_nxt = S_CN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // single result: reject or cancel on empty
      S_ONE: begin
        if (slot_free) begin
          ev        = '{valid: 1'b1, id: id_r, kind: kind_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      // second elapsed: decrement head
      S_TK_RD: begin
        rd_addr   = head_r;
        state_nxt = S_TK_DEC;
      end
      S_TK_DEC: begin
        nxt_nxt = rd_node.nxt;
        if (rd_node.dly != '0) begin
          wr_en   = 1'b1;
          wr_addr = head_r;
          wr_node = '{nxt: rd_node.nxt, dly: rd_node.dly - 1'b1};
        end
        more_nxt = 1'b0;
        if (rd_node.dly > DLY_W'(1)) state_nxt = S_IDLE;
        else if (count_r > CNT_W'(1)) state_nxt = S_REL_RD;
        else state_nxt = S_REL_EMIT;
      end
      // look ahead at the next entry so last is known
      S_REL_RD: begin
        rd_addr   = nxt_r;
        state_nxt = S_REL_CHK;
      end
      S_REL_CHK: begin
        more_nxt  = (rd_node.dly == '0);
        nn_nxt    = rd_node.nxt;
        state_nxt = S_REL_EMIT;
      end
      S_REL_EMIT: begin
        if (slot_free) begin
          ev = '{valid: 1'b1, id: head_r, kind: EV_EXPIRED, last: !more_r};
          flags_nxt[head_r] = 1'b0;
          head_nxt  = nxt_r;
          count_nxt = count_r - 1'b1;
          if (more_r) begin
            nxt_nxt = nn_r;
            if (count_r > CNT_W'(2)) begin
              state_nxt = S_REL_RD;
            end else begin
              more_nxt  = 1'b0;
              state_nxt = S_REL_EMIT;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      // insert: walk from the head
      S_IN_RD: begin
        rd_addr   = nxt_r;
        state_nxt = S_IN_CMP;
      end
      S_IN_CMP: begin
        if (rem_r >= rd_node.dly) begin
          rem_nxt      = rem_r - rd_node.dly;
          prev_nxt     = nxt_r;
          prev_dly_nxt = rd_node.dly;
          prev_v_nxt   = 1'b1;
          nxt_nxt      = rd_node.nxt;
          k_nxt        = k_inc;
          if (k_inc < count_r) begin
            state_nxt = S_IN_RD;
          end else begin
            end_nxt   = 1'b1;
            state_nxt = S_IN_NEW;
          end
        end else begin
          succ_dly_nxt = rd_node.dly - rem_r;
          nn_nxt       = rd_node.nxt;
          end_nxt      = 1'b0;
          state_nxt    = S_IN_NEW;
        end
      end
      S_IN_NEW: begin
        wr_en     = 1'b1;
        wr_addr   = id_r;
        wr_node   = '{nxt: nxt_r, dly: rem_r};
        state_nxt = end_r ? S_IN_LINK : S_IN_SUCC;
      end
      S_IN_SUCC: begin
        wr_en     = 1'b1;
        wr_addr   = nxt_r;
        wr_node   = '{nxt: nn_r, dly: succ_dly_r};
        state_nxt = S_IN_LINK;
      end
      S_IN_LINK: begin
        if (prev_v_r) begin
          wr_en   = 1'b1;
          wr_addr = prev_r;
          wr_node = '{nxt: id_r, dly: prev_dly_r};
        end else begin
          head_nxt = id_r;
        end
        count_nxt       = count_r + 1'b1;
        flags_nxt[id_r] = 1'b1;
        state_nxt       = S_IDLE;
      end
      // cancel head, passing its delta on
      S_CN_RD: begin
        rd_addr   = head_r;
        state_nxt = S_CN_A;
      end
      S_CN_A: begin
        rem_nxt   = rd_node.dly;
        nxt_nxt   = rd_node.nxt;
        state_nxt = (count_r > CNT_W'(1)) ? S_CN_B : S_CN_EMIT;
        rd_addr   = rd_node.nxt;
      end
      S_CN_B: begin
        wr_en     = 1'b1;
        wr_addr   = nxt_r;
        wr_node   = '{nxt: rd_node.nxt,
                      dly: sum[DLY_W] ? {DLY_W{1'b1}} : sum[DLY_W-1:0]};
        state_nxt = S_CN_EMIT;
      end
      S_CN_EMIT: begin
        if (slot_free) begin
          ev = '{valid: 1'b1, id: head_r, kind: EV_CANCELLED, last: 1'b1};
          flags_nxt[head_r] = 1'b0;
          head_nxt  = nxt_r;
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      flags_r <= '0;
      presc_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
      presc_r <= presc_nxt;
      head_r  <= head_nxt;
    end
    id_r       <= id_nxt;
    kind_r     <= kind_nxt;
    rem_r      <= rem_nxt;
    nxt_r      <= nxt_nxt;
    nn_r       <= nn_nxt;
    prev_r     <= prev_nxt;
    prev_dly_r <= prev_dly_nxt;
    prev_v_r   <= prev_v_nxt;
    succ_dly_r <= succ_dly_nxt;
    end_r      <= end_nxt;
    k_r        <= k_nxt;
    more_r     <= more_nxt;
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES)) else $error("entry count overflow");
  a_flags_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flags_r) == int'(count_r)) else $error("flags out of step with count");
  a_head_queued: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> flags_r[head_r]) else $error("head id not queued");
  a_rel_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL_EMIT || state_r == S_CN_EMIT) |-> count_r != '0)
    else $error("release from empty list");

endmodule

[src/delta_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// delta_timer_queue_unit
// Delta-list timer queue: tick, insert and cancel-head words in, expiry,
// cancel, reject and empty words out.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, op, entry_id, delay  | input
//  out     | out_valid/out_ready, event_id/kind/last | output
//  cfg     | cfg_we, cfg_wdata (ticks per second)    | input
//
// A tick that does not complete a second only steps the prescaler; an insert
// walks the list entry by entry from the head, a cancel reads the head and
// any successor, a completed second decrements the head and releases each
// expired entry in turn: paced by the single read port of the node RAM.
// Synchronous active-low reset; the node RAM needs no clearing.
// A stalled result holds the sequencer only when a further word is due.
// ----------------------------------------------------------------------------
module delta_timer_queue_unit import dtq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [ID_W-1:0]  in_entry_id,
  input  logic [DLY_W-1:0] in_delay,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  out_event_id,
  output logic [1:0]       out_event_kind,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [TPS_W-1:0] cfg_wdata
);

  logic [TPS_W-1:0] tps_r;
  logic             out_valid_r;
  logic [ID_W-1:0]  out_id_r;
  logic [1:0]       out_kind_r;
  logic             out_last_r;
  logic             slot_free;
  event_t           ev;

  assign slot_free = !out_valid_r || out_ready;

  dtq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_entry_id (in_entry_id),
    .in_delay    (in_delay),
    .tps         (tps_r),
    .slot_free   (slot_free),
    .ev          (ev)
  );

  // config register and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tps_r <= cfg_wdata;
      if (ev.valid) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (ev.valid) begin
      out_id_r   <= ev.id;
      out_kind_r <= ev.kind;
      out_last_r <= ev.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_id   = out_id_r;
  assign out_event_kind = out_kind_r;
  assign out_last       = out_last_r;

endmodule
